>>> hdl/sdt_pkg.sv
// Shared types and constants for the scan deflector and test pattern timer.
package sdt_pkg;

	localparam int ROW_PIXELS = 16;
	localparam int ROW_BYTES  = ROW_PIXELS / 8;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REG_ON_TICKS   = 2'd0;
	localparam logic [1:0] REG_WAIT_TICKS = 2'd1;
	localparam logic [1:0] REG_LINE_TICKS = 2'd2;
	localparam logic [1:0] REG_PATTERN    = 2'd3;

	localparam logic [15:0] ON_TICKS_RST   = 16'd200;
	localparam logic [15:0] WAIT_TICKS_RST = 16'd300;
	localparam logic [15:0] LINE_TICKS_RST = 16'd1500;
	localparam logic [2:0]  PATTERN_RST    = 3'd0;

	localparam logic [2:0] PAT_KEEP     = 3'd0;
	localparam logic [2:0] PAT_WALK     = 3'd1;
	localparam logic [2:0] PAT_HALF     = 3'd2;
	localparam logic [2:0] PAT_CHECKER  = 3'd3;
	localparam logic [2:0] PAT_FULL     = 3'd4;
	localparam logic [2:0] PAT_EDGES    = 3'd5;
	localparam logic [2:0] PAT_BLANK    = 3'd6;
	localparam logic [2:0] PAT_BORDER   = 3'd7;

	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] BYTE_ONE     = 8'h01;
	localparam logic [7:0] BYTE_BIT4    = 8'h10;
	localparam logic [7:0] BYTE_CHECK   = 8'h55;
	localparam logic [7:0] BYTE_CHECK_SH = 8'hAA;
	localparam logic [7:0] BYTE_FULL    = 8'hFF;
	localparam logic [7:0] BYTE_TAIL    = 8'hF0;

	// bit 0 up pin, bit 1 down pin, 1 = released
	localparam logic [1:0] PINS_FREE = 2'b11;
	localparam logic [1:0] PINS_UP   = 2'b10;
	localparam logic [1:0] PINS_DOWN = 2'b01;

	typedef enum logic [3:0] {
		DPH_REST_A = 4'b0001,
		DPH_UP     = 4'b0010,
		DPH_REST_B = 4'b0100,
		DPH_DOWN   = 4'b1000
	} dfl_phase_t;

	typedef struct packed {
		logic        up_n;
		logic        down_n;
		logic [15:0] cycles;
	} dfl_stat_t;

endpackage

>>> hdl/scan_deflector_and_test_pattern_timer_top.sv
// Top level: configuration registers, input transfer and result register.
// One tick is taken per cycle unless stalled; its result is presented in the next cycle;
// both timers, the phase sequencer and the row generator update in a single registered step,
// so the input side only stalls while a finished result is held by a stall on the output side.
module scan_deflector_and_test_pattern_timer_top import sdt_pkg::*; #(
	parameter int LINE_COUNT = 16,
	localparam int LINE_W    = $clog2(LINE_COUNT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  tick,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  up_drive_n,
	output logic                  down_drive_n,
	output logic [LINE_W-1:0]     line_index,
	output logic [15:0]           row_bits,
	output logic                  row_updated,
	output logic [15:0]           deflect_cycles
);

	logic [15:0] on_ticks_q;
	logic [15:0] wait_ticks_q;
	logic [15:0] line_ticks_q;
	logic [2:0]  pattern_q;

	logic        out_valid_q;
	logic        up_n_q;
	logic        down_n_q;
	logic [LINE_W-1:0] line_q;
	logic [15:0] row_q;
	logic        fired_q;
	logic [15:0] cycles_q;

	logic        cfg_wr;
	logic [1:0]  cfg_idx;
	logic        in_xfer;
	logic        adv;
	dfl_stat_t   dfl_stat;
	logic        line_fired;
	logic [LINE_W-1:0] line_nxt;
	logic [15:0] row_nxt;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_ticks_q   <= ON_TICKS_RST;
			wait_ticks_q <= WAIT_TICKS_RST;
			line_ticks_q <= LINE_TICKS_RST;
			pattern_q    <= PATTERN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ON_TICKS:   on_ticks_q   <= pwdata[15:0];
				REG_WAIT_TICKS: wait_ticks_q <= pwdata[15:0];
				REG_LINE_TICKS: line_ticks_q <= pwdata[15:0];
				REG_PATTERN:    pattern_q    <= pwdata[2:0];
				default:        pattern_q    <= pattern_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ON_TICKS:   prdata = CFG_DATA_W'(on_ticks_q);
			REG_WAIT_TICKS: prdata = CFG_DATA_W'(wait_ticks_q);
			REG_LINE_TICKS: prdata = CFG_DATA_W'(line_ticks_q);
			REG_PATTERN:    prdata = CFG_DATA_W'(pattern_q);
			default:        prdata = '0;
		endcase
	end

	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;
	assign adv      = in_xfer && tick;

	sdt_deflect u_deflect (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.on_ticks   (on_ticks_q),
		.wait_ticks (wait_ticks_q),
		.stat_nxt   (dfl_stat)
	);

	sdt_line #(
		.LINE_COUNT (LINE_COUNT),
		.LINE_W     (LINE_W)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.period   (line_ticks_q),
		.pattern  (pattern_q),
		.fired    (line_fired),
		.line_nxt (line_nxt),
		.row_nxt  (row_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			up_n_q   <= dfl_stat.up_n;
			down_n_q <= dfl_stat.down_n;
			cycles_q <= dfl_stat.cycles;
			line_q   <= line_nxt;
			row_q    <= row_nxt;
			fired_q  <= line_fired;
		end
	end

	assign out_valid      = out_valid_q;
	assign up_drive_n     = up_n_q;
	assign down_drive_n   = down_n_q;
	assign line_index     = line_q;
	assign row_bits       = row_q;
	assign row_updated    = fired_q;
	assign deflect_cycles = cycles_q;

endmodule

>>> hdl/sdt_deflect.sv
// Deflector timer and four-phase drive sequencer.
module sdt_deflect import sdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [15:0] on_ticks,
	input  logic [15:0] wait_ticks,
	output dfl_stat_t   stat_nxt
);

	logic [15:0] cnt_q;
	logic [15:0] reload_q;
	dfl_phase_t  phase_q;
	logic [1:0]  pins_q;
	logic [15:0] cycles_q;

	logic [15:0] cnt_inc;
	logic        fire;
	logic [15:0] reload_nxt;
	dfl_phase_t  phase_nxt;
	logic [1:0]  pins_nxt;
	logic [15:0] cycles_nxt;
	logic [1:0]  pins_out;
	logic [15:0] cycles_out;

	assign cnt_inc = cnt_q + 16'd1;
	assign fire    = cnt_inc > reload_q;

	always_comb begin
		reload_nxt = reload_q;
		phase_nxt  = phase_q;
		pins_nxt   = pins_q;
		cycles_nxt = cycles_q;
		unique case (phase_q)
			DPH_REST_A: begin
				pins_nxt   = PINS_FREE;
				cycles_nxt = cycles_q + 16'd1;
				reload_nxt = wait_ticks;
				phase_nxt  = DPH_UP;
			end
			DPH_UP: begin
				pins_nxt   = PINS_UP;
				reload_nxt = on_ticks;
				phase_nxt  = DPH_REST_B;
			end
			DPH_REST_B: begin
				pins_nxt   = PINS_FREE;
				reload_nxt = wait_ticks;
				phase_nxt  = DPH_DOWN;
			end
			DPH_DOWN: begin
				pins_nxt   = PINS_DOWN;
				reload_nxt = on_ticks;
				phase_nxt  = DPH_REST_A;
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			reload_q <= ON_TICKS_RST;
			phase_q  <= DPH_REST_A;
			pins_q   <= PINS_UP;
			cycles_q <= '0;
		end else if (adv) begin
			if (fire) begin
				cnt_q    <= '0;
				reload_q <= reload_nxt;
				phase_q  <= phase_nxt;
				pins_q   <= pins_nxt;
				cycles_q <= cycles_nxt;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

	assign pins_out   = (adv && fire) ? pins_nxt : pins_q;
	assign cycles_out = (adv && fire) ? cycles_nxt : cycles_q;

	assign stat_nxt.up_n   = pins_out[0];
	assign stat_nxt.down_n = pins_out[1];
	assign stat_nxt.cycles = cycles_out;

	a_pins_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		pins_q != 2'b00)
		else $error("both deflector pins driven");

	a_cycles_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cycles_q != $past(cycles_q)) |-> $past(adv && fire && phase_q == DPH_REST_A))
		else $error("cycle count moved outside a completed cycle");

endmodule

>>> hdl/sdt_line.sv
// Line timer, line index and test row generator.
module sdt_line import sdt_pkg::*; #(
	parameter int LINE_COUNT = 16,
	parameter int LINE_W     = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [15:0]       period,
	input  logic [2:0]        pattern,
	output logic              fired,
	output logic [LINE_W-1:0] line_nxt,
	output logic [15:0]       row_nxt
);

	logic [15:0]                  cnt_q;
	logic [LINE_W-1:0]            line_q;
	logic [ROW_BYTES-1:0][7:0]    row_q;

	logic [15:0]                  cnt_inc;
	logic                         fire;
	logic [LINE_W-1:0]            line_step;
	logic [7:0]                   n_ext;
	logic [ROW_BYTES-1:0][7:0]    row_gen;
	logic [7:0]                   fill;

	assign cnt_inc   = cnt_q + 16'd1;
	assign fire      = cnt_inc > period;
	assign line_step = (line_q >= LINE_W'(LINE_COUNT)) ? '0 : line_q + LINE_W'(1);
	assign n_ext     = 8'(line_step);

	always_comb begin
		fill    = BYTE_ZERO;
		row_gen = row_q;
		unique case (pattern)
			PAT_KEEP:    fill = BYTE_ZERO;
			PAT_WALK:    fill = BYTE_ONE << n_ext[2:0];
			PAT_HALF:    fill = n_ext[2] ? BYTE_BIT4 : BYTE_ONE;
			PAT_CHECKER: fill = n_ext[0] ? BYTE_CHECK_SH : BYTE_CHECK;
			PAT_FULL:    fill = BYTE_FULL;
			PAT_EDGES:   fill = BYTE_ZERO;
			PAT_BLANK:   fill = BYTE_ZERO;
			PAT_BORDER:  fill = (line_step == '0 || line_step == LINE_W'(LINE_COUNT))
				? BYTE_FULL : BYTE_ZERO;
			default:     fill = BYTE_ZERO;
		endcase
		if (pattern != PAT_KEEP) begin
			for (int i = 0; i < ROW_BYTES; i++) begin
				row_gen[i] = fill;
			end
		end
		if (pattern == PAT_EDGES) begin
			row_gen[0]           = BYTE_ONE;
			row_gen[ROW_BYTES-1] = BYTE_TAIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			line_q <= '0;
			row_q  <= '0;
		end else if (adv) begin
			if (fire) begin
				cnt_q  <= '0;
				line_q <= line_step;
				row_q  <= row_gen;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

	assign fired    = adv && fire;
	assign line_nxt = fired ? line_step : line_q;
	assign row_nxt  = fired ? row_gen : row_q;

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LINE_W'(LINE_COUNT))
		else $error("line index beyond line count");

	a_row_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q != $past(row_q)) |-> $past(adv && fire && pattern != PAT_KEEP))
		else $error("row changed without a line step");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the scan deflector and test pattern timer: ticks in, scan state out.
`timescale 1ns / 100ps

module testbench;
	import sdt_pkg::*;

	localparam int LINE_COUNT  = 16;
	localparam int LINE_W      = $clog2(LINE_COUNT + 1);
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_TICKS = 70;
	localparam int PHASES      = 15;

	typedef enum logic [2:0] {
		ENTER_PAUSE_A = 3'd1,
		ENTER_UP      = 3'd2,
		ENTER_PAUSE_B = 3'd3,
		ENTER_DOWN    = 3'd4
	} sweep_step_t;

	typedef enum int {
		GAPS_NONE,
		GAPS_SEND,
		GAPS_RECV,
		GAPS_BOTH
	} gap_mode_t;

	typedef struct {
		logic              up_n;
		logic              down_n;
		logic [LINE_W-1:0] line;
		logic [15:0]       row;
		logic              fired;
		logic [15:0]       cycles;
	} scan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  tick;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  up_drive_n;
	logic                  down_drive_n;
	logic [LINE_W-1:0]     line_index;
	logic [15:0]           row_bits;
	logic                  row_updated;
	logic [15:0]           deflect_cycles;

	logic [15:0]       sweep_on;
	logic [15:0]       sweep_wait;
	logic [15:0]       line_period;
	logic [2:0]        pattern;
	logic [15:0]       sweep_count;
	logic [15:0]       sweep_reload;
	sweep_step_t       sweep_next;
	logic [1:0]        pins;
	logic [15:0]       sweeps_done;
	logic [15:0]       line_count;
	logic [LINE_W-1:0] line_num;
	logic [15:0]       row;

	scan_result_t pending_scans[$];
	scan_result_t oldest_scan;
	int           errors = 0;
	int           quiet_cycles = 0;
	int           send_gap_pct = 0;
	int           recv_stall_pct = 0;

	scan_deflector_and_test_pattern_timer_top #(
		.LINE_COUNT(LINE_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.tick(tick),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.up_drive_n(up_drive_n),
		.down_drive_n(down_drive_n),
		.line_index(line_index),
		.row_bits(row_bits),
		.row_updated(row_updated),
		.deflect_cycles(deflect_cycles)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void reset_scan_state();
		sweep_on     = ON_TICKS_RST;
		sweep_wait   = WAIT_TICKS_RST;
		line_period  = LINE_TICKS_RST;
		pattern      = PATTERN_RST;
		sweep_count  = 16'd0;
		sweep_reload = ON_TICKS_RST;
		sweep_next   = ENTER_PAUSE_A;
		pins         = PINS_UP;
		sweeps_done  = 16'd0;
		line_count   = 16'd0;
		line_num     = '0;
		row          = {BYTE_ZERO, BYTE_ZERO};
	endfunction

	function automatic scan_result_t scan_step(input logic t);
		scan_result_t r;
		r.fired = 1'b0;
		if (t) begin
			sweep_count = sweep_count + 16'd1;
			line_count  = line_count + 16'd1;
			if (sweep_reload < sweep_count) begin
				case (sweep_next)
					ENTER_PAUSE_A: begin
						pins         = PINS_FREE;
						sweeps_done  = sweeps_done + 16'd1;
						sweep_reload = sweep_wait;
						sweep_next   = ENTER_UP;
					end
					ENTER_UP: begin
						pins         = PINS_UP;
						sweep_reload = sweep_on;
						sweep_next   = ENTER_PAUSE_B;
					end
					ENTER_PAUSE_B: begin
						pins         = PINS_FREE;
						sweep_reload = sweep_wait;
						sweep_next   = ENTER_DOWN;
					end
					ENTER_DOWN: begin
						pins         = PINS_DOWN;
						sweep_reload = sweep_on;
						sweep_next   = ENTER_PAUSE_A;
					end
					default: ;
				endcase
				sweep_count = 16'd0;
			end
			if (line_period < line_count) begin
				line_num = (line_num == LINE_COUNT) ? '0 : line_num + 1'b1;
				case (pattern)
					PAT_WALK:    row = {2{8'(BYTE_ONE << line_num[2:0])}};
					PAT_HALF:    row = {2{line_num[2] ? BYTE_BIT4 : BYTE_ONE}};
					PAT_CHECKER: row = {2{line_num[0] ? BYTE_CHECK_SH : BYTE_CHECK}};
					PAT_FULL:    row = {BYTE_FULL, BYTE_FULL};
					PAT_EDGES:   row = {BYTE_TAIL, BYTE_ONE};
					PAT_BLANK:   row = {BYTE_ZERO, BYTE_ZERO};
					PAT_BORDER:  row = {2{(line_num == 0 || line_num == LINE_COUNT) ?
						BYTE_FULL : BYTE_ZERO}};
					default: ;
				endcase
				line_count = 16'd0;
				r.fired    = 1'b1;
			end
		end
		r.up_n   = pins[0];
		r.down_n = pins[1];
		r.line   = line_num;
		r.row    = row;
		r.cycles = sweeps_done;
		return r;
	endfunction

	task automatic set_gaps(input gap_mode_t mode);
		send_gap_pct   = (mode == GAPS_SEND) ? 70 : (mode == GAPS_BOTH) ? 26 : 0;
		recv_stall_pct = (mode == GAPS_RECV) ? 70 : (mode == GAPS_BOTH) ? 26 : 0;
	endtask

	task automatic send_tick(input logic t);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		tick     <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_scans.push_back(scan_step(t));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ON_TICKS:   sweep_on    = value[15:0];
			REG_WAIT_TICKS: sweep_wait  = value[15:0];
			REG_LINE_TICKS: line_period = value[15:0];
			REG_PATTERN:    pattern     = value[2:0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_scans.size() == 0) begin
				$error("result transfer with no tick outstanding");
				errors++;
			end else begin
				oldest_scan = pending_scans.pop_front();
				check_field("up_drive_n", 16'(oldest_scan.up_n), 16'(up_drive_n));
				check_field("down_drive_n", 16'(oldest_scan.down_n), 16'(down_drive_n));
				check_field("line_index", 16'(oldest_scan.line), 16'(line_index));
				check_field("row_bits", oldest_scan.row, row_bits);
				check_field("row_updated", 16'(oldest_scan.fired), 16'(row_updated));
				check_field("deflect_cycles", oldest_scan.cycles, deflect_cycles);
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) || psel === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_reset_state();
		set_gaps(GAPS_NONE);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	task automatic test_patterns();
		set_gaps(GAPS_BOTH);
		cfg_write(REG_ON_TICKS, '0);
		cfg_write(REG_WAIT_TICKS, '0);
		cfg_write(REG_LINE_TICKS, '0);
		for (int p = 0; p < 8; p++) begin
			cfg_write(REG_PATTERN, CFG_DATA_W'(p));
			send_tick(1'b1);
			send_tick(p == 3 ? 1'b0 : 1'b1);
		end
	endtask

	task automatic test_random_sweeps();
		for (int ph = 0; ph < PHASES; ph++) begin
			set_gaps(gap_mode_t'(ph % 4));
			cfg_write(REG_ON_TICKS, ($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 400) : $urandom_range(0, 10));
			cfg_write(REG_WAIT_TICKS, ($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 400) : $urandom_range(0, 10));
			case ($urandom_range(0, 9))
				0:       cfg_write(REG_LINE_TICKS, 32'hFFFF);
				1:       cfg_write(REG_LINE_TICKS, $urandom_range(0, 60));
				default: cfg_write(REG_LINE_TICKS, $urandom_range(0, 5));
			endcase
			cfg_write(REG_PATTERN, $urandom_range(0, 7));
			for (int i = 0; i < PHASE_TICKS; i++)
				send_tick($urandom_range(0, 99) < 88);
		end
	endtask

	task automatic test_full_scale();
		set_gaps(GAPS_RECV);
		cfg_write(REG_LINE_TICKS, 32'hFFFF);
		cfg_write(REG_ON_TICKS, 32'hFFFF);
		cfg_write(REG_WAIT_TICKS, 32'hFFFF);
		while (sweep_reload != 16'hFFFF)
			send_tick(1'b1);
		repeat (12) send_tick(1'b1);
		cfg_write(REG_LINE_TICKS, '0);
		cfg_write(REG_PATTERN, CFG_DATA_W'(PAT_BORDER));
		repeat (3) send_tick(1'b1);
	endtask

	initial begin
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		in_valid <= 1'b0;
		tick     <= 1'b0;
		reset_scan_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_patterns();
		test_random_sweeps();
		test_full_scale();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_scans.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
hdl/sdt_pkg.sv
hdl/sdt_deflect.sv
hdl/sdt_line.sv
hdl/scan_deflector_and_test_pattern_timer_top.sv
dv/testbench.sv
